// ===== src/spectrum_bar_smoother_autogain_defines.svh =====
// ----------------------------------------------------------------------------
// Spectrum bar smoother assertion macros
// Shared clocking and reset gating for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_SMOOTHER_AUTOGAIN_DEFINES_SVH
`define SPECTRUM_BAR_SMOOTHER_AUTOGAIN_DEFINES_SVH

// Assert a property on the rising clock, gated by reset.
`define SBSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert an overlapping implication on the rising clock, gated by reset.
`define SBSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/sbsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum bar smoother package
// Configuration struct, per-bar state record, register indexes and constants.
// ----------------------------------------------------------------------------
package sbsa_pkg;

  typedef struct packed {
    logic [17:0] noise_red;
    logic [23:0] gravity;
    logic        autosens;
  } cfg_t;

  typedef struct packed {
    logic [31:0] peak;
    logic [16:0] fall;
    logic [31:0] integ;
    logic [31:0] prev;
  } bar_ent_t;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_NOISE_RED = 2'd0;
  localparam logic [1:0] REG_GRAVITY   = 2'd1;
  localparam logic [1:0] REG_AUTOSENS  = 2'd2;

  localparam logic [17:0] NR_RESET    = 18'd50462;
  localparam logic [23:0] GRAV_RESET  = 24'd65536;
  localparam logic        AS_RESET    = 1'b1;
  localparam logic [31:0] GAIN_RESET  = 32'd16777216;

  localparam logic [23:0] GRAV_MIN     = 24'd65536;
  localparam logic [31:0] ONE_Q16      = 32'd65536;
  localparam logic [17:0] NR_THRESHOLD = 18'd6553;
  localparam logic [17:0] FALL_STEP    = 18'd1835;
  localparam logic [16:0] FALL_MAX     = 17'd131071;

  localparam logic [30:0] GAIN_DOWN  = 31'd1052266988;
  localparam logic [30:0] GAIN_UP    = 31'd1074815566;
  localparam logic [30:0] GAIN_FIRST = 31'd1181116006;

endpackage

// ===== src/spectrum_bar_smoother_autogain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum bar smoother with automatic gain
// Per-bar gravity falloff, integral smoothing and frame-level sensitivity gain.
// ----------------------------------------------------------------------------
// Input channel: one band level per item (bar index, Q16.16 level, last-bar and
// silent-frame flags), valid/ready. Output channel: one item per input item
// (bar index, smoothed Q16.16 height, frame-end flag, Q8.24 gain), valid/ready.
// Configuration goes through the APB-style port; write it only while idle.
// Every multiply goes through one 34x32 multiplier with a registered product,
// stepped by the state machine: an item passes the read, scale, square,
// gravity, decay and integrate states to the output state, and a last bar that
// updates the gain adds one or two gain multiply passes on the way. The next
// item is taken only once the result has loaded into the output register.
// The block takes one item at a time and is not ready while an item is in work.
// The output register lets the next item enter while a result waits; a
// finished item holds in the final state until the receiver takes the one
// ahead of it.
// After reset a clearing pass writes zero to every per-bar state entry, one
// entry per cycle; no item is accepted until it ends.
// ----------------------------------------------------------------------------
`include "spectrum_bar_smoother_autogain_defines.svh"

module spectrum_bar_smoother_autogain
  import sbsa_pkg::*;
#(
  parameter int unsigned MAX_BARS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        bar_index_i,
  input  logic [31:0]       band_level_i,
  input  logic              last_bar_i,
  input  logic              frame_silent_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_bar_o,
  output logic [31:0]       bar_level_o,
  output logic              frame_end_o,
  output logic [31:0]       gain_now_o
);

  localparam int unsigned IDX_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam logic [16:0] RECIP = 17'(65536 / MAX_BARS);
  localparam logic [10:0] MB    = 11'(MAX_BARS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BARS - 1);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_READ  = 11'b000_0000_0100,
    S_SCALE = 11'b000_0000_1000,
    S_SQR   = 11'b000_0001_0000,
    S_GRAV  = 11'b000_0010_0000,
    S_DECAY = 11'b000_0100_0000,
    S_INTEG = 11'b000_1000_0000,
    S_GMUL  = 11'b001_0000_0000,
    S_GWR   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  cfg_t cfg;

  sbsa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e           state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [31:0]      gain_q, gain_d;
  logic             first_q, first_d;
  logic             ovs_q, ovs_d;
  logic             out_valid_q, out_valid_d;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       bar_q, bar_d;
  logic [31:0]      level_q, level_d;
  logic             last_q, last_d;
  logic             silent_q, silent_d;
  bar_ent_t         ent_q;
  logic [65:0]      prod_q;
  logic             fall_q, fall_d;
  logic             dbig_q, dbig_d;
  logic             dzero_q, dzero_d;
  logic [31:0]      h_q, h_d;
  logic [30:0]      k_q, k_d;
  logic             more_q, more_d;
  logic [7:0]       out_bar_q, out_bar_d;
  logic [31:0]      out_level_q, out_level_d;
  logic             out_end_q, out_end_d;
  logic [31:0]      out_gain_q, out_gain_d;
  logic [31:0]      res_q, res_d;

  bar_ent_t         mem_q [MAX_BARS];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  bar_ent_t         mem_wdata;

  logic [33:0]      mul_a;
  logic [31:0]      mul_b;

  // bar index modulo MAX_BARS: reciprocal estimate, one correction
  logic [24:0]      q_prod;
  logic [19:0]      q_back;
  logic [10:0]      rem_raw;
  logic [10:0]      rem_fix;
  logic [IDX_W-1:0] idx_in;

  assign q_prod  = 25'(bar_index_i) * 25'(RECIP);
  assign q_back  = 20'(q_prod[24:16]) * 20'(MB);
  assign rem_raw = 11'(bar_index_i) - q_back[10:0];
  assign rem_fix = (rem_raw >= MB) ? (rem_raw - MB) : rem_raw;
  assign idx_in  = rem_fix[IDX_W-1:0];

  logic [23:0] grav_eff;
  logic [31:0] dlo;
  logic [34:0] sum_int;
  logic [31:0] total;
  logic        ov_now;
  logic        ov_eff;
  logic [17:0] fall_inc;

  assign grav_eff = (cfg.gravity < GRAV_MIN) ? GRAV_MIN : cfg.gravity;
  assign dlo      = prod_q[47:16];
  assign sum_int  = 35'(prod_q[49:16]) + 35'(h_q);
  assign total    = (|sum_int[34:32]) ? 32'hFFFF_FFFF : sum_int[31:0];
  assign ov_now   = cfg.autosens && (total > ONE_Q16);
  assign ov_eff   = ovs_q || ov_now;
  assign fall_inc = 18'(ent_q.fall) + FALL_STEP;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    gain_d      = gain_q;
    first_d     = first_q;
    ovs_d       = ovs_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    bar_d       = bar_q;
    level_d     = level_q;
    last_d      = last_q;
    silent_d    = silent_q;
    fall_d      = fall_q;
    dbig_d      = dbig_q;
    dzero_d     = dzero_q;
    h_d         = h_q;
    k_d         = k_q;
    more_d      = more_q;
    res_d       = res_q;
    out_bar_d   = out_bar_q;
    out_level_d = out_level_q;
    out_end_d   = out_end_q;
    out_gain_d  = out_gain_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mul_a       = '0;
    mul_b       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d    = idx_in;
          bar_d    = bar_index_i;
          level_d  = band_level_i;
          last_d   = last_bar_i;
          silent_d = frame_silent_i;
          state_d  = S_READ;
        end
      end
      S_READ: begin
        mul_a   = 34'(level_q);
        mul_b   = gain_q;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        if (cfg.autosens) begin
          level_d = (|prod_q[63:56]) ? 32'hFFFF_FFFF : prod_q[55:24];
        end
        mul_a   = 34'(ent_q.fall);
        mul_b   = 32'(ent_q.fall);
        state_d = S_SQR;
      end
      S_SQR: begin
        fall_d  = (level_q < ent_q.prev) && (cfg.noise_red > NR_THRESHOLD);
        mul_a   = prod_q[33:0];
        mul_b   = 32'(grav_eff);
        state_d = S_GRAV;
      end
      S_GRAV: begin
        dbig_d  = |prod_q[57:48];
        dzero_d = (dlo == '0) && !(|prod_q[57:48]);
        mul_a   = 34'(ent_q.peak);
        mul_b   = 32'd0 - dlo;
        state_d = S_DECAY;
      end
      S_DECAY: begin
        priority if (!fall_q) begin
          h_d = level_q;
        end else if (dbig_q) begin
          h_d = '0;
        end else if (dzero_q) begin
          h_d = ent_q.peak;
        end else begin
          h_d = prod_q[63:32];
        end
        mul_a   = 34'(ent_q.integ);
        mul_b   = 32'(cfg.noise_red);
        state_d = S_INTEG;
      end
      S_INTEG: begin
        mem_we          = 1'b1;
        mem_wdata.peak  = fall_q ? ent_q.peak : level_q;
        mem_wdata.fall  = !fall_q ? '0 :
                          (fall_inc > 18'(FALL_MAX)) ? FALL_MAX : fall_inc[16:0];
        mem_wdata.integ = total;
        mem_wdata.prev  = h_q;
        res_d           = ov_now ? ONE_Q16 : total;
        state_d         = S_OUT;
        if (last_q) begin
          ovs_d = 1'b0;
          if (cfg.autosens) begin
            priority if (ov_eff) begin
              k_d     = GAIN_DOWN;
              more_d  = 1'b0;
              first_d = 1'b0;
              state_d = S_GMUL;
            end else if (!silent_q) begin
              k_d     = GAIN_UP;
              more_d  = first_q;
              state_d = S_GMUL;
            end else begin
              state_d = S_OUT;
            end
          end
        end else if (ov_now) begin
          ovs_d = 1'b1;
        end
      end
      S_GMUL: begin
        mul_a   = 34'(gain_q);
        mul_b   = 32'(k_q);
        state_d = S_GWR;
      end
      S_GWR: begin
        gain_d = prod_q[62] ? 32'hFFFF_FFFF : prod_q[61:30];
        if (more_q) begin
          k_d     = GAIN_FIRST;
          more_d  = 1'b0;
          state_d = S_GMUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_bar_d   = bar_q;
          out_level_d = res_q;
          out_end_d   = last_q;
          out_gain_d  = gain_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      gain_q      <= GAIN_RESET;
      first_q     <= 1'b1;
      ovs_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      gain_q      <= gain_d;
      first_q     <= first_d;
      ovs_q       <= ovs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    bar_q       <= bar_d;
    level_q     <= level_d;
    last_q      <= last_d;
    silent_q    <= silent_d;
    prod_q      <= 66'(mul_a) * 66'(mul_b);
    fall_q      <= fall_d;
    dbig_q      <= dbig_d;
    dzero_q     <= dzero_d;
    h_q         <= h_d;
    k_q         <= k_d;
    more_q      <= more_d;
    res_q       <= res_d;
    out_bar_q   <= out_bar_d;
    out_level_q <= out_level_d;
    out_end_q   <= out_end_d;
    out_gain_q  <= out_gain_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    ent_q <= mem_q[idx_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_bar_o   = out_bar_q;
  assign bar_level_o = out_level_q;
  assign frame_end_o = out_end_q;
  assign gain_now_o  = out_gain_q;

  `SBSA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `SBSA_ASSERT(a_gain_on_last_bar, !$stable(gain_q) |-> last_q, "gain moved off a last bar")
  `SBSA_ASSERT_IMP(a_ovs_clear_at_end, (state_q == S_OUT) && last_q, !ovs_q, "overshoot kept")
  `SBSA_ASSERT(a_hold_when_full, (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT), "result dropped")

endmodule

// ===== src/sbsa_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum bar smoother configuration registers
// APB-style register file for noise reduction, gravity and autosens.
// ----------------------------------------------------------------------------
module sbsa_regs
  import sbsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_NOISE_RED: cfg_d.noise_red = pwdata[17:0];
        REG_GRAVITY:   cfg_d.gravity   = pwdata[23:0];
        REG_AUTOSENS:  cfg_d.autosens  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NOISE_RED: prdata = {14'd0, cfg_q.noise_red};
      REG_GRAVITY:   prdata = {8'd0, cfg_q.gravity};
      REG_AUTOSENS:  prdata = {31'd0, cfg_q.autosens};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.noise_red <= NR_RESET;
      cfg_q.gravity   <= GRAV_RESET;
      cfg_q.autosens  <= AS_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
